// ===== hdl/ecefenu_pkg.sv =====
`default_nettype none
package ecefenu_pkg;

  localparam int COORD_BITS_DEF = 34;
  localparam int UNIT_FRAC_BITS_DEF = 30;

  localparam logic [1:0] REG_ORIGIN_X = 2'd0;
  localparam logic [1:0] REG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] REG_ORIGIN_Z = 2'd2;

  localparam logic [2:0] DJ_E0 = 3'd0;
  localparam logic [2:0] DJ_E1 = 3'd1;
  localparam logic [2:0] DJ_U0 = 3'd2;
  localparam logic [2:0] DJ_U1 = 3'd3;
  localparam logic [2:0] DJ_U2 = 3'd4;
  localparam logic [2:0] DJ_N2 = 3'd5;

  localparam logic [3:0] BI_E0 = 4'd0;
  localparam logic [3:0] BI_E1 = 4'd1;
  localparam logic [3:0] BI_E2 = 4'd2;
  localparam logic [3:0] BI_N0 = 4'd3;
  localparam logic [3:0] BI_N1 = 4'd4;
  localparam logic [3:0] BI_N2 = 4'd5;
  localparam logic [3:0] BI_U0 = 4'd6;
  localparam logic [3:0] BI_U1 = 4'd7;
  localparam logic [3:0] BI_U2 = 4'd8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_SQRT_H_GO,
    ST_SQRT_H_WAIT,
    ST_SQRT_R_GO,
    ST_SQRT_R_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_NMUL,
    ST_PROJ,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    MS_OX,
    MS_OY,
    MS_OZ,
    MS_NE0,
    MS_NE1,
    MS_PROJ
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef struct packed {
    logic       load_point;
    mul_sel_t   mul_sel;
    logic [3:0] bidx;
    logic [1:0] didx;
    acc_op_t    acc_op;
    logic       cap_s;
    logic       cap_r2;
    logic       sqrt_start;
    logic       sqrt_sel;
    logic       cap_h;
    logic       cap_r;
    logic       div_start;
    logic [2:0] div_job;
    logic       div_wr;
    logic       wr_n0;
    logic       wr_n1;
    logic       round_en;
    logic [1:0] round_k;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic degen;
    logic sqrt_done;
    logic div_done;
  } status_t;

endpackage
`default_nettype wire

// ===== hdl/ecefenu_isqrt.sv =====
`default_nettype none
module ecefenu_isqrt #(
  parameter int ROOT_BITS = 34
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [2*ROOT_BITS-1:0] x,
  output logic                   done,
  output logic [ROOT_BITS-1:0]   root
);
  localparam int RW = ROOT_BITS + 3;
  localparam int CW = $clog2(ROOT_BITS);

  logic [2*ROOT_BITS-1:0] xs;
  logic [RW-1:0]          rem;
  logic [RW-1:0]          rem_sh;
  logic [RW-1:0]          trial;
  logic [CW-1:0]          cnt;
  logic                   busy;
  logic                   ge;

  assign rem_sh = {rem[ROOT_BITS:0], xs[2*ROOT_BITS-1 -: 2]};
  assign trial  = RW'({root, 2'b01});
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xs   <= x;
      rem  <= '0;
      root <= '0;
      cnt  <= CW'(ROOT_BITS - 1);
    end else if (busy) begin
      xs   <= xs << 2;
      rem  <= ge ? (rem_sh - trial) : rem_sh;
      root <= {root[ROOT_BITS-2:0], ge};
      cnt  <= cnt - 1'b1;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/ecefenu_div.sv =====
`default_nettype none
module ecefenu_div #(
  parameter int NUM_BITS = 66,
  parameter int DEN_BITS = 35
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                done,
  output logic [NUM_BITS-1:0] quot
);
  localparam int CW = $clog2(NUM_BITS);

  logic [DEN_BITS:0]   rem;
  logic [DEN_BITS:0]   rem_sh;
  logic [DEN_BITS:0]   dext;
  logic [DEN_BITS-1:0] dr;
  logic [CW-1:0]       cnt;
  logic                busy;
  logic                ge;

  assign rem_sh = {rem[DEN_BITS-1:0], quot[NUM_BITS-1]};
  assign dext   = {1'b0, dr};
  assign ge     = (rem_sh >= dext);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= num;
      dr   <= den;
      rem  <= '0;
      cnt  <= CW'(NUM_BITS - 1);
    end else if (busy) begin
      rem  <= ge ? (rem_sh - dext) : rem_sh;
      quot <= {quot[NUM_BITS-2:0], ge};
      cnt  <= cnt - 1'b1;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/ecefenu_dp.sv =====
`default_nettype none
module ecefenu_dp #(
  parameter int COORD_BITS = 34,
  parameter int UNIT_FRAC_BITS = 30
) (
  input  logic                   clk,
  input  logic                   rst,
  input  ecefenu_pkg::cmd_t      cmd,
  output ecefenu_pkg::status_t   status,
  input  logic                   cfg_wr,
  input  logic [1:0]             cfg_index,
  input  logic [COORD_BITS-1:0]  cfg_data,
  input  logic [COORD_BITS-1:0]  point_x,
  input  logic [COORD_BITS-1:0]  point_y,
  input  logic [COORD_BITS-1:0]  point_z,
  input  logic                   last_point,
  output logic [COORD_BITS-1:0]  east,
  output logic [COORD_BITS-1:0]  north,
  output logic [COORD_BITS-1:0]  up,
  output logic                   saturated,
  output logic                   bad_origin,
  output logic                   last_result
);
  import ecefenu_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int F  = UNIT_FRAC_BITS;
  localparam int DW = C + 1;
  localparam int UW = F + 2;
  localparam int MW = (DW > UW) ? DW : UW;
  localparam int PW = 2 * MW;
  localparam int NW = C + F + 2;
  localparam int QW = PW - F;

  logic [C-1:0]           ox, oy, oz;
  logic [C-1:0]           ax, ay, az;
  logic signed [DW-1:0]   d [3];
  logic                   last_r;
  logic signed [UW-1:0]   basis [9];
  logic signed [MW-1:0]   ma, mb;
  logic signed [PW-1:0]   prod;
  logic signed [PW-1:0]   acc;
  logic [2*C-1:0]         s_reg, r2_reg;
  logic [C-1:0]           h_reg, r_reg;
  logic                   degen;
  logic [C-1:0]           res [3];
  logic                   sat_r;

  logic [2*C-1:0]         sq_x;
  logic                   sq_done;
  logic [C-1:0]           sq_root;

  logic [C-1:0]           dv_num, dv_den;
  logic                   dv_neg;
  logic [3:0]             dv_idx;
  logic [NW-1:0]          dv_n;
  logic [DW-1:0]          dv_d;
  logic                   dv_done;
  logic [NW-1:0]          dv_q;
  logic [F:0]             dv_mag;
  logic signed [UW-1:0]   dv_unit;

  logic                   pneg;
  logic [PW-1:0]          pmag, prnd;
  logic signed [UW-1:0]   rv;

  logic                   aneg;
  logic [PW-1:0]          amag, arnd;
  logic [QW-1:0]          qr;
  logic [C-1:0]           rval;
  logic                   rsat;

  localparam logic [QW-1:0] NEG_MAX = QW'(1) << (C - 1);
  localparam logic [QW-1:0] POS_MAX = NEG_MAX - QW'(1);
  localparam logic [NW-1:0] UNIT_LIM = NW'(1) << F;
  localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

  assign ax = ox[C-1] ? (~ox + 1'b1) : ox;
  assign ay = oy[C-1] ? (~oy + 1'b1) : oy;
  assign az = oz[C-1] ? (~oz + 1'b1) : oz;

  always_ff @(posedge clk) begin
    if (rst) begin
      ox <= '0;
      oy <= '0;
      oz <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_ORIGIN_X: ox <= cfg_data;
        REG_ORIGIN_Y: oy <= cfg_data;
        REG_ORIGIN_Z: oz <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_sel)
      MS_OX: begin
        ma = MW'($signed(ox));
        mb = MW'($signed(ox));
      end
      MS_OY: begin
        ma = MW'($signed(oy));
        mb = MW'($signed(oy));
      end
      MS_OZ: begin
        ma = MW'($signed(oz));
        mb = MW'($signed(oz));
      end
      MS_NE0: begin
        ma = MW'(basis[BI_U2]);
        mb = MW'(basis[BI_E0]);
      end
      MS_NE1: begin
        ma = MW'(basis[BI_U2]);
        mb = MW'(basis[BI_E1]);
      end
      MS_PROJ: begin
        ma = MW'(d[cmd.didx]);
        mb = MW'(basis[cmd.bidx]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    case (cmd.acc_op)
      ACC_LOAD: acc <= prod;
      ACC_ADD:  acc <= acc + prod;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      degen <= 1'b0;
    end else if (cmd.cap_s) begin
      degen <= (acc[2*C-1:0] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_s) s_reg <= acc[2*C-1:0];
    if (cmd.cap_r2) r2_reg <= acc[2*C-1:0];
    if (cmd.cap_h) h_reg <= sq_root;
    if (cmd.cap_r) r_reg <= sq_root;
  end

  assign sq_x = cmd.sqrt_sel ? r2_reg : s_reg;

  ecefenu_isqrt #(
    .ROOT_BITS(C)
  ) u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.sqrt_start),
    .x    (sq_x),
    .done (sq_done),
    .root (sq_root)
  );

  always_comb begin
    unique case (cmd.div_job)
      DJ_E0: begin
        dv_num = ay;
        dv_neg = !oy[C-1] && (oy != '0);
        dv_den = h_reg;
        dv_idx = BI_E0;
      end
      DJ_E1: begin
        dv_num = ax;
        dv_neg = ox[C-1];
        dv_den = h_reg;
        dv_idx = BI_E1;
      end
      DJ_U0: begin
        dv_num = ax;
        dv_neg = ox[C-1];
        dv_den = r_reg;
        dv_idx = BI_U0;
      end
      DJ_U1: begin
        dv_num = ay;
        dv_neg = oy[C-1];
        dv_den = r_reg;
        dv_idx = BI_U1;
      end
      DJ_U2: begin
        dv_num = az;
        dv_neg = oz[C-1];
        dv_den = r_reg;
        dv_idx = BI_U2;
      end
      default: begin
        dv_num = h_reg;
        dv_neg = 1'b0;
        dv_den = r_reg;
        dv_idx = BI_N2;
      end
    endcase
  end

  assign dv_n = NW'({dv_num, {(F + 1){1'b0}}}) + NW'(dv_den);
  assign dv_d = {dv_den, 1'b0};

  ecefenu_div #(
    .NUM_BITS(NW),
    .DEN_BITS(DW)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (dv_n),
    .den  (dv_d),
    .done (dv_done),
    .quot (dv_q)
  );

  assign dv_mag  = (dv_q > UNIT_LIM) ? UNIT_LIM[F:0] : dv_q[F:0];
  assign dv_unit = dv_neg ? -$signed({1'b0, dv_mag}) : $signed({1'b0, dv_mag});

  assign pneg = prod[PW-1];
  assign pmag = pneg ? PW'(-prod) : PW'(prod);
  assign prnd = (pmag + HALF) >> F;
  assign rv   = $signed({1'b0, prnd[F:0]});

  always_ff @(posedge clk) begin
    if (cmd.div_wr) basis[dv_idx] <= dv_unit;
    if (cmd.wr_n0) begin
      basis[BI_N0] <= pneg ? rv : -rv;
      basis[BI_E2] <= '0;
    end
    if (cmd.wr_n1) basis[BI_N1] <= pneg ? -rv : rv;
  end

  assign aneg = acc[PW-1];
  assign amag = aneg ? PW'(-acc) : PW'(acc);
  assign arnd = (amag + HALF) >> F;
  assign qr   = arnd[QW-1:0];

  always_comb begin
    rsat = 1'b0;
    if (aneg) begin
      if (qr > NEG_MAX) begin
        rsat = 1'b1;
        rval = NEG_MAX[C-1:0];
      end else begin
        rval = C'(~qr + 1'b1);
      end
    end else begin
      if (qr > POS_MAX) begin
        rsat = 1'b1;
        rval = POS_MAX[C-1:0];
      end else begin
        rval = qr[C-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_point) begin
      d[0]   <= DW'($signed(point_x)) - DW'($signed(ox));
      d[1]   <= DW'($signed(point_y)) - DW'($signed(oy));
      d[2]   <= DW'($signed(point_z)) - DW'($signed(oz));
      last_r <= last_point;
      sat_r  <= 1'b0;
    end else if (cmd.round_en) begin
      res[cmd.round_k] <= rval;
      sat_r            <= sat_r | rsat;
    end
    if (cmd.out_load) begin
      east        <= degen ? '0 : res[0];
      north       <= degen ? '0 : res[1];
      up          <= degen ? '0 : res[2];
      saturated   <= degen ? 1'b0 : sat_r;
      bad_origin  <= degen;
      last_result <= last_r;
    end
  end

  assign status.degen     = degen;
  assign status.sqrt_done = sq_done;
  assign status.div_done  = dv_done;
endmodule
`default_nettype wire

// ===== hdl/ecefenu_ctrl.sv =====
`default_nettype none
module ecefenu_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 cfg_wr,
  input  logic [1:0]           cfg_index,
  input  ecefenu_pkg::status_t status,
  output ecefenu_pkg::cmd_t    cmd
);
  import ecefenu_pkg::*;

  localparam logic [3:0] SQ_LAST   = 4'd4;
  localparam logic [3:0] NM_LAST   = 4'd2;
  localparam logic [3:0] PROJ_LAST = 4'd10;

  state_t     state, state_next;
  logic [3:0] step, step_next;
  logic [2:0] job, job_next;
  logic       basis_ready, basis_ready_next;
  logic       out_valid_next;
  logic       cfg_hit;

  assign cfg_hit = cfg_wr && (cfg_index == REG_ORIGIN_X || cfg_index == REG_ORIGIN_Y ||
                              cfg_index == REG_ORIGIN_Z);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      step        <= '0;
      job         <= DJ_E0;
      basis_ready <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      step        <= step_next;
      job         <= job_next;
      basis_ready <= basis_ready_next;
      out_valid   <= out_valid_next;
    end
  end

  always_comb begin
    state_next       = state;
    step_next        = step;
    job_next         = job;
    basis_ready_next = basis_ready;
    out_valid_next   = out_valid && !out_ready;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          step_next = '0;
          if (!basis_ready) state_next = ST_SQ;
          else if (status.degen) state_next = ST_FIN;
          else state_next = ST_PROJ;
        end
      end
      ST_SQ: begin
        if (step == SQ_LAST) begin
          if (status.degen) begin
            basis_ready_next = 1'b1;
            state_next       = ST_FIN;
          end else begin
            state_next = ST_SQRT_H_GO;
          end
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_SQRT_H_GO: state_next = ST_SQRT_H_WAIT;
      ST_SQRT_H_WAIT: begin
        if (status.sqrt_done) state_next = ST_SQRT_R_GO;
      end
      ST_SQRT_R_GO: state_next = ST_SQRT_R_WAIT;
      ST_SQRT_R_WAIT: begin
        if (status.sqrt_done) begin
          job_next   = DJ_E0;
          state_next = ST_DIV_GO;
        end
      end
      ST_DIV_GO: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          if (job == DJ_N2) begin
            step_next  = '0;
            state_next = ST_NMUL;
          end else begin
            job_next   = job + 1'b1;
            state_next = ST_DIV_GO;
          end
        end
      end
      ST_NMUL: begin
        if (step == NM_LAST) begin
          basis_ready_next = 1'b1;
          step_next        = '0;
          state_next       = ST_PROJ;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_PROJ: begin
        if (step == PROJ_LAST) state_next = ST_FIN;
        else step_next = step + 1'b1;
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (cfg_hit) basis_ready_next = 1'b0;
  end

  always_comb begin
    cmd      = '0;
    in_ready = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: cmd.load_point = in_valid;
      ST_SQ: begin
        case (step) inside
          4'd0: cmd.mul_sel = MS_OX;
          4'd1: begin
            cmd.mul_sel = MS_OY;
            cmd.acc_op  = ACC_LOAD;
          end
          4'd2: begin
            cmd.mul_sel = MS_OZ;
            cmd.acc_op  = ACC_ADD;
          end
          4'd3: begin
            cmd.acc_op = ACC_ADD;
            cmd.cap_s  = 1'b1;
          end
          default: cmd.cap_r2 = 1'b1;
        endcase
      end
      ST_SQRT_H_GO: begin
        cmd.sqrt_start = 1'b1;
        cmd.sqrt_sel   = 1'b0;
      end
      ST_SQRT_H_WAIT: cmd.cap_h = status.sqrt_done;
      ST_SQRT_R_GO: begin
        cmd.sqrt_start = 1'b1;
        cmd.sqrt_sel   = 1'b1;
      end
      ST_SQRT_R_WAIT: cmd.cap_r = status.sqrt_done;
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_job   = job;
      end
      ST_DIV_WAIT: begin
        cmd.div_job = job;
        cmd.div_wr  = status.div_done;
      end
      ST_NMUL: begin
        case (step) inside
          4'd0: cmd.mul_sel = MS_NE1;
          4'd1: begin
            cmd.mul_sel = MS_NE0;
            cmd.wr_n0   = 1'b1;
          end
          default: cmd.wr_n1 = 1'b1;
        endcase
      end
      ST_PROJ: begin
        cmd.bidx = step;
        if (step <= 4'd8) cmd.mul_sel = MS_PROJ;
        case (step) inside
          4'd0, 4'd3, 4'd6: cmd.didx = 2'd0;
          4'd1, 4'd4, 4'd7: cmd.didx = 2'd1;
          default:          cmd.didx = 2'd2;
        endcase
        case (step) inside
          4'd1, 4'd4, 4'd7:             cmd.acc_op = ACC_LOAD;
          4'd2, 4'd3, 4'd5, 4'd6, 4'd8, 4'd9: cmd.acc_op = ACC_ADD;
          default:                      cmd.acc_op = ACC_NONE;
        endcase
        case (step) inside
          4'd4: begin
            cmd.round_en = 1'b1;
            cmd.round_k  = 2'd0;
          end
          4'd7: begin
            cmd.round_en = 1'b1;
            cmd.round_k  = 2'd1;
          end
          4'd10: begin
            cmd.round_en = 1'b1;
            cmd.round_k  = 2'd2;
          end
          default: ;
        endcase
      end
      ST_FIN: cmd.out_load = !out_valid || out_ready;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ===== hdl/ecef_to_local_enu.sv =====
// With the basis in place, each item is worked through the shared multiplier and accumulator,
// and a new item is taken only once the result of the last one is in the output register.
// The first item after reset or an origin write first builds the basis with the bit-serial
// square root and divider, which are skipped when the origin has zero x and zero y.
// Reset is synchronous and active high; it clears the origin to zero and marks the basis
// as not built, and the output register comes up empty.
`default_nettype none
module ecef_to_local_enu #(
  parameter int COORD_BITS = ecefenu_pkg::COORD_BITS_DEF,
  parameter int UNIT_FRAC_BITS = ecefenu_pkg::UNIT_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] point_x,
  input  logic [COORD_BITS-1:0] point_y,
  input  logic [COORD_BITS-1:0] point_z,
  input  logic                  last_point,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] east,
  output logic [COORD_BITS-1:0] north,
  output logic [COORD_BITS-1:0] up,
  output logic                  saturated,
  output logic                  bad_origin,
  output logic                  last_result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data
);
  import ecefenu_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  ecefenu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cfg_wr   (cfg_wr),
    .cfg_index(cfg_index),
    .status   (status),
    .cmd      (cmd)
  );

  ecefenu_dp #(
    .COORD_BITS    (COORD_BITS),
    .UNIT_FRAC_BITS(UNIT_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .cfg_wr     (cfg_wr),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .point_x    (point_x),
    .point_y    (point_y),
    .point_z    (point_z),
    .last_point (last_point),
    .east       (east),
    .north      (north),
    .up         (up),
    .saturated  (saturated),
    .bad_origin (bad_origin),
    .last_result(last_result)
  );
endmodule
`default_nettype wire

// ===== hdl/ecefenu_chk.sv =====
`default_nettype none
module ecefenu_chk #(
  parameter int COORD_BITS = ecefenu_pkg::COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] east,
  input logic [COORD_BITS-1:0] north,
  input logic [COORD_BITS-1:0] up,
  input logic                  saturated,
  input logic                  bad_origin,
  input logic                  last_result
);
  localparam logic [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
  localparam logic [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS - 1){1'b0}}};

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(east) && $stable(north) &&
      $stable(up) && $stable(saturated) && $stable(bad_origin) && $stable(last_result))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is at work");

  a_bad_origin_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_origin |-> east == '0 && north == '0 && up == '0 && !saturated)
    else $error("bad origin result is not zero");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> east == CMAX || east == CMIN || north == CMAX ||
      north == CMIN || up == CMAX || up == CMIN)
    else $error("saturated flag without a clipped component");
endmodule

bind ecef_to_local_enu ecefenu_chk #(.COORD_BITS(COORD_BITS)) u_chk (.*);
`default_nettype wire

// ===== sim/tb_ecef_to_local_enu.sv =====
`default_nettype none
module tb_ecef_to_local_enu;
  timeunit 1ns;
  timeprecision 1ps;
  import ecefenu_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int FB = UNIT_FRAC_BITS_DEF;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam logic [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
  localparam int CYCLE_LIMIT = 600000;
  localparam int TOTAL_ITEMS = 1850;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB-1:0] z;
    logic          last;
  } point_t;

  typedef struct packed {
    logic [CB-1:0] e;
    logic [CB-1:0] n;
    logic [CB-1:0] u;
    logic          sat;
    logic          bad;
    logic          last;
  } enu_t;

  typedef struct packed {
    logic [1:0]    idx;
    logic [CB-1:0] data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CB-1:0] point_x = '0;
  logic [CB-1:0] point_y = '0;
  logic [CB-1:0] point_z = '0;
  logic last_point = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CB-1:0] east, north, up;
  logic saturated, bad_origin, last_result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [CB-1:0] cfg_data = '0;

  point_t pending_points[$];
  reg_write_t pending_writes[$];
  enu_t expected_enu[$];

  longint origin[3];
  longint basis[9];
  bit basis_built;
  bit polar_origin;

  int errors = 0;
  int n_accepted = 0;
  int cycles = 0;
  int send_idle = 21;
  int recv_idle = 49;
  int hold_left = 0;
  bit hold_done = 1'b0;

  ecef_to_local_enu DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .point_x(point_x), .point_y(point_y), .point_z(point_z), .last_point(last_point),
    .out_valid(out_valid), .out_ready(out_ready),
    .east(east), .north(north), .up(up),
    .saturated(saturated), .bad_origin(bad_origin), .last_result(last_result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic longint to_signed(logic [CB-1:0] v);
    longint r;
    r = longint'(v);
    if (v[CB-1]) r = r - (longint'(1) <<< CB);
    return r;
  endfunction

  function automatic logic [63:0] magnitude(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] floor_root(logic [127:0] x);
    logic [63:0] r;
    logic [63:0] t;
    logic [127:0] sq;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (64'd1 << b);
      sq = {64'd0, t} * {64'd0, t};
      if (x >= sq) r = t;
    end
    return r;
  endfunction

  function automatic longint unit_ratio(logic [63:0] num, bit neg, logic [63:0] den);
    logic [127:0] n;
    logic [127:0] q;
    longint v;
    n = ({64'd0, num} << (FB + 1)) + {64'd0, den};
    q = n / ({64'd0, den} << 1);
    v = (q > (128'd1 << FB)) ? (longint'(1) <<< FB) : longint'(q[63:0]);
    return neg ? -v : v;
  endfunction

  function automatic longint unit_product(longint a, longint b);
    logic [127:0] p;
    longint v;
    p = ({64'd0, magnitude(a)} * {64'd0, magnitude(b)}) + (128'd1 << (FB - 1));
    v = longint'(p >> FB);
    return ((a < 0) != (b < 0)) ? -v : v;
  endfunction

  function automatic logic [CB-1:0] project_onto(longint d[3], int k, inout bit sat);
    logic signed [127:0] acc;
    logic signed [127:0] a;
    logic signed [127:0] b;
    logic [127:0] m;
    logic [127:0] q;
    acc = '0;
    for (int i = 0; i < 3; i++) begin
      a = d[i];
      b = basis[k + i];
      acc = acc + a * b;
    end
    m = (acc < 0) ? -acc : acc;
    q = (m + (128'd1 << (FB - 1))) >> FB;
    if (acc < 0) begin
      if (q > (128'd1 << (CB - 1))) begin
        sat = 1'b1;
        return CMIN;
      end
      return CB'(-q);
    end
    if (q > {1'b0, 127'(CMAX)}) begin
      sat = 1'b1;
      return CMAX;
    end
    return CB'(q);
  endfunction

  function automatic void build_frame();
    logic [127:0] s;
    logic [127:0] rr;
    logic [63:0] h;
    logic [63:0] r;
    logic [63:0] ax, ay, az;
    ax = magnitude(origin[0]);
    ay = magnitude(origin[1]);
    az = magnitude(origin[2]);
    s = {64'd0, ax} * {64'd0, ax} + {64'd0, ay} * {64'd0, ay};
    rr = s + {64'd0, az} * {64'd0, az};
    basis_built = 1'b1;
    polar_origin = (s == 0);
    if (polar_origin) begin
      for (int i = 0; i < 9; i++) basis[i] = 0;
      return;
    end
    h = floor_root(s);
    r = floor_root(rr);
    basis[0] = unit_ratio(ay, origin[1] > 0, h);
    basis[1] = unit_ratio(ax, origin[0] < 0, h);
    basis[2] = 0;
    basis[6] = unit_ratio(ax, origin[0] < 0, r);
    basis[7] = unit_ratio(ay, origin[1] < 0, r);
    basis[8] = unit_ratio(az, origin[2] < 0, r);
    basis[3] = -unit_product(basis[8], basis[1]);
    basis[4] = unit_product(basis[8], basis[0]);
    basis[5] = unit_ratio(h, 1'b0, r);
  endfunction

  function automatic enu_t local_coords(point_t p);
    enu_t res;
    longint d[3];
    bit sat;
    sat = 1'b0;
    res = '0;
    if (!basis_built) build_frame();
    res.last = p.last;
    if (polar_origin) begin
      res.bad = 1'b1;
      return res;
    end
    d[0] = to_signed(p.x) - origin[0];
    d[1] = to_signed(p.y) - origin[1];
    d[2] = to_signed(p.z) - origin[2];
    res.e = project_onto(d, 0, sat);
    res.n = project_onto(d, 3, sat);
    res.u = project_onto(d, 6, sat);
    res.sat = sat;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [CB-1:0] got, logic [CB-1:0] want);
    $display("error: %s got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ecef_to_local_enu: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index != REG_UNUSED) begin
          origin[cfg_index] = to_signed(cfg_data);
          basis_built = 1'b0;
        end
      end
      if (!cfg_valid || cfg_ready) begin
        if (pending_writes.size() > 0) begin
          reg_write_t w;
          w = pending_writes.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= w.idx;
          cfg_data <= w.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_enu.push_back(local_coords({point_x, point_y, point_z, last_point}));
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_points.size() > 0 && $urandom_range(99) >= send_idle) begin
          point_t p;
          p = pending_points.pop_front();
          in_valid <= 1'b1;
          point_x <= p.x;
          point_y <= p.y;
          point_z <= p.z;
          last_point <= p.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (n_accepted < TOTAL_ITEMS / 3) begin
      send_idle <= 21;
      recv_idle <= 49;
    end else if (n_accepted < 2 * TOTAL_ITEMS / 3) begin
      send_idle <= 49;
      recv_idle <= 21;
    end else begin
      send_idle <= 0;
      recv_idle <= 0;
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && n_accepted == 300) begin
      hold_left <= 500;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
      if (out_valid && out_ready) begin
        if (expected_enu.size() == 0) begin
          report_mismatch("unexpected item, east", east, '0);
        end else begin
          enu_t w;
          w = expected_enu.pop_front();
          if (east !== w.e) report_mismatch("east", east, w.e);
          if (north !== w.n) report_mismatch("north", north, w.n);
          if (up !== w.u) report_mismatch("up", up, w.u);
          if (saturated !== w.sat) report_mismatch("saturated", CB'(saturated), CB'(w.sat));
          if (bad_origin !== w.bad) report_mismatch("bad_origin", CB'(bad_origin), CB'(w.bad));
          if (last_result !== w.last) report_mismatch("last_result", CB'(last_result), CB'(w.last));
        end
      end
    end
  end

  function automatic logic [CB-1:0] any_coord();
    logic [CB-1:0] v;
    v[31:0] = $urandom;
    v[CB-1:32] = 2'($urandom_range(3));
    return v;
  endfunction

  function automatic logic [CB-1:0] near(logic [CB-1:0] c);
    int span;
    longint offs;
    span = ($urandom_range(9) == 0) ? 31 : int'($urandom_range(20, 4));
    offs = longint'($urandom_range(32'((64'd1 << span) - 64'd1)));
    return c + CB'(offs - (longint'(1) <<< (span - 1)));
  endfunction

  task automatic add_point(logic [CB-1:0] x, logic [CB-1:0] y, logic [CB-1:0] z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    p.last = 1'($urandom_range(1));
    pending_points.push_back(p);
  endtask

  task automatic drain();
    while (pending_points.size() > 0 || in_valid || expected_enu.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_origin(logic [CB-1:0] x, logic [CB-1:0] y, logic [CB-1:0] z);
    pending_writes.push_back({REG_ORIGIN_X, x});
    pending_writes.push_back({REG_ORIGIN_Y, y});
    pending_writes.push_back({REG_ORIGIN_Z, z});
    while (pending_writes.size() > 0 || cfg_valid) @(posedge clk);
  endtask

  logic [CB-1:0] ox_set[10];
  logic [CB-1:0] oy_set[10];
  logic [CB-1:0] oz_set[10];

  initial begin
    ox_set = '{34'd1633000000, CMAX, CMIN, 34'd0, 34'd1, 34'd0, 34'd1200000000, CMAX, 34'd0,
               34'd0};
    oy_set = '{34'd300000000, CMAX, CMIN, 34'd0, 34'd0, -34'd1, -34'd900000000, CMIN, CMIN,
               34'd0};
    oz_set = '{34'd1200000000, CMAX, CMIN, 34'd5, 34'd0, 34'd0, 34'd1000000000, 34'd0, CMAX,
               34'd0};
    for (int i = 0; i < 10; i++) begin
      ox_set[9] = any_coord();
      oy_set[9] = any_coord();
      oz_set[9] = any_coord();
    end
    origin = '{0, 0, 0};
    basis_built = 1'b0;
    polar_origin = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    add_point('0, '0, '0);
    add_point(CMAX, CMAX, CMAX);
    add_point(CMIN, CMIN, CMIN);
    drain();

    set_origin(ox_set[0], oy_set[0], oz_set[0]);
    add_point(ox_set[0], oy_set[0], oz_set[0]);
    add_point(CMAX, CMAX, CMAX);
    add_point(CMIN, CMIN, CMIN);
    add_point(CMAX, CMIN, CMAX);
    add_point(CMIN, CMAX, CMIN);
    add_point('0, '0, '0);
    add_point(34'h2AAAAAAAA, 34'h155555555, 34'h0FFFF0000);
    add_point(ox_set[0] + 34'd256, oy_set[0], oz_set[0] - 34'd1);
    drain();
    pending_writes.push_back({REG_UNUSED, CMAX});
    while (pending_writes.size() > 0 || cfg_valid) @(posedge clk);
    add_point(ox_set[0], oy_set[0] + 34'd1000, oz_set[0]);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      set_origin(ox_set[ph], oy_set[ph], oz_set[ph]);
      for (int k = 0; k < 182; k++) begin
        if ($urandom_range(4) == 0)
          add_point(any_coord(), any_coord(), any_coord());
        else
          add_point(near(ox_set[ph]), near(oy_set[ph]), near(oz_set[ph]));
      end
      drain();
    end

    repeat (30) @(posedge clk);
    if (errors == 0 && expected_enu.size() == 0) begin
      $display("ecef_to_local_enu: match");
    end else begin
      $display("ecef_to_local_enu: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/ecefenu_pkg.sv
hdl/ecefenu_isqrt.sv
hdl/ecefenu_div.sv
hdl/ecefenu_dp.sv
hdl/ecefenu_ctrl.sv
hdl/ecef_to_local_enu.sv
hdl/ecefenu_chk.sv
sim/tb_ecef_to_local_enu.sv
